// ===== rtl/core/cts_pkg.sv =====
// shared constants, payload types and walker types for the column to span converter
package cts_pkg;

    // view size
    localparam int ROWS    = 64;
    localparam int COLUMNS = 1024;

    // field widths fixed by the payload
    localparam int ROW_FW = 6;
    localparam int COL_FW = 10;

    // start column memory address width
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    // signed row index, holds -1 .. ROWS
    localparam int IDX_W = ROW_FW + 2;

    typedef logic signed [IDX_W-1:0] idx_t;

    localparam idx_t IDX_ROWS    = IDX_W'(ROWS);
    localparam idx_t IDX_LASTROW = IDX_W'(ROWS - 1);
    localparam idx_t IDX_NONE    = '1;

    typedef struct packed {
        logic [COL_FW-1:0] column;
        logic [ROW_FW-1:0] top_row;
        logic [ROW_FW-1:0] bottom_row;
        logic              first_col;
        logic              last_col;
    } in_item_t;

    typedef struct packed {
        logic [ROW_FW-1:0] span_row;
        logic [COL_FW-1:0] span_start;
        logic [COL_FW-1:0] span_end;
        logic              run_last;
    } out_item_t;

    // memory request from the row walker
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ROW_FW-1:0] row;
        logic [COL_FW-1:0] col;
        logic              run_last;
    } walk_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE_TOP,
        ST_CLOSE_BOT,
        ST_OPEN_TOP,
        ST_OPEN_BOT,
        ST_FLUSH
    } walk_state_t;

endpackage

// ===== rtl/core/column_to_span_converter.sv =====
// top level of the column to span converter: start column memory and span output path
//
// channel  dir  handshake           payload
// s_       in   s_valid / s_ready   cts_pkg::in_item_t  (one coverage column)
// m_       out  m_valid / m_ready   cts_pkg::out_item_t (one closed span)
//
// the walker accepts an item only when idle, then steps through its closed, opened
// and flushed rows one at a time; s_ready stays low until that walk is done
// a span reaches m_ from its memory read through the read stage and the output register
// aresetn is synchronous, active low; the memory needs no clearing pass
// a stall on m_ holds the read stage, which holds the walker's close and flush
// steps; opening steps go on regardless
module column_to_span_converter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cts_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cts_pkg::out_item_t  m_data
);

    // start column of each open row
    logic [cts_pkg::COL_FW-1:0] start_mem [cts_pkg::ROWS];
    logic [cts_pkg::COL_FW-1:0] rdata_reg;

    cts_pkg::walk_req_t req;
    logic issue_ok;

    // read stage: span metadata waiting for the memory data
    logic                        s1_vld_reg;
    logic [cts_pkg::ROW_FW-1:0]  s1_row_reg;
    logic [cts_pkg::COL_FW-1:0]  s1_end_reg;
    logic                        s1_last_reg;
    logic                        s1_move;

    logic                        m_valid_reg;
    cts_pkg::out_item_t          m_data_reg;

    logic [cts_pkg::ROW_W-1:0]   addr;

    cts_row_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .issue_ok (issue_ok),
        .req      (req)
    );

    assign addr     = req.row[cts_pkg::ROW_W-1:0];
    // read stage advances into the output register when that is free or draining
    assign s1_move  = s1_vld_reg && (!m_valid_reg || m_ready);
    // a new read only when the read stage is free next cycle
    assign issue_ok = !s1_vld_reg || s1_move;

    // memory write port and registered read port; read data holds while stalled
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            start_mem[addr] <= req.col;
        end
        if (req.rd_en) begin
            rdata_reg <= start_mem[addr];
        end
    end

    // read stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (req.rd_en) begin
            s1_vld_reg <= 1'b1;
        end else if (s1_move) begin
            s1_vld_reg <= 1'b0;
        end
    end

    // read stage payload
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            s1_row_reg  <= req.row;
            s1_end_reg  <= req.col;
            s1_last_reg <= req.run_last;
        end
    end

    // output register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_data_reg.span_row   <= s1_row_reg;
            m_data_reg.span_start <= rdata_reg;
            m_data_reg.span_end   <= s1_end_reg;
            m_data_reg.run_last   <= s1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a stalled read stage must not be overwritten by a new read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && !s1_move) |-> !req.rd_en)
        else $error("read issued while read stage stalled");

    // the walker never reads and writes the memory in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.rd_en && req.wr_en))
        else $error("memory read and write in the same cycle");

    // no memory access while the walker waits for a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(req.rd_en || req.wr_en))
        else $error("memory access while walker idle");

    // a read always fills the read stage, so no span is lost
    assert property (@(posedge aclk) disable iff (!aresetn)
        req.rd_en |=> s1_vld_reg)
        else $error("read stage lost a span");

endmodule

// ===== rtl/core/cts_row_walker.sv =====
// row walker: steps through closed, opened and flushed rows one per cycle; close and flush steps wait for issue_ok
module cts_row_walker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cts_pkg::in_item_t   s_data,
    input  logic                issue_ok,
    output cts_pkg::walk_req_t  req
);

    cts_pkg::walk_state_t state_reg, state_next;

    cts_pkg::idx_t t1_reg, t1_next;
    cts_pkg::idx_t b1_reg, b1_next;
    cts_pkg::idx_t ot_reg, ot_next;
    cts_pkg::idx_t ob_reg, ob_next;
    cts_pkg::idx_t fr_reg, fr_next;
    cts_pkg::idx_t t2_reg, t2_next;
    cts_pkg::idx_t b2_reg, b2_next;
    logic [cts_pkg::COL_FW-1:0] x_reg, x_next;
    logic last_reg, last_next;
    logic empty_reg, empty_next;

    cts_pkg::idx_t prev_top_reg, prev_top_next;
    cts_pkg::idx_t prev_bottom_reg, prev_bottom_next;
    logic prev_empty_reg, prev_empty_next;

    cts_pkg::idx_t in_t2, in_b2, in_t1, in_b1;
    logic in_empty;
    logic in_view;

    function automatic logic [cts_pkg::IDX_W-1:0] IDX_ZEXT(input logic [cts_pkg::ROW_FW-1:0] v);
        return cts_pkg::IDX_W'(v);
    endfunction

    // first phase that still has work, in processing order
    function automatic cts_pkg::walk_state_t next_phase(
        input cts_pkg::idx_t t1, input cts_pkg::idx_t b1,
        input cts_pkg::idx_t ot, input cts_pkg::idx_t ob,
        input cts_pkg::idx_t fr, input cts_pkg::idx_t t2,
        input cts_pkg::idx_t b2, input logic ce, input logic lst);
        priority if (t1 < t2 && t1 <= b1) begin
            return cts_pkg::ST_CLOSE_TOP;
        end else if (b1 > b2 && b1 >= t1) begin
            return cts_pkg::ST_CLOSE_BOT;
        end else if (!ce && ot < t1 && ot <= ob) begin
            return cts_pkg::ST_OPEN_TOP;
        end else if (!ce && ob > b1 && ob >= ot) begin
            return cts_pkg::ST_OPEN_BOT;
        end else if (lst && !ce && fr <= b2) begin
            return cts_pkg::ST_FLUSH;
        end else begin
            return cts_pkg::ST_IDLE;
        end
    endfunction

    // true while any span is still to come for this item
    function automatic logic more_spans(
        input cts_pkg::idx_t t1, input cts_pkg::idx_t b1,
        input cts_pkg::idx_t fr, input cts_pkg::idx_t t2,
        input cts_pkg::idx_t b2, input logic ce, input logic lst);
        return (t1 < t2 && t1 <= b1) || (b1 > b2 && b1 >= t1) ||
               (lst && !ce && fr <= b2);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= cts_pkg::ST_IDLE;
            prev_top_reg    <= '0;
            prev_bottom_reg <= '0;
            prev_empty_reg  <= 1'b1;
        end else begin
            state_reg       <= state_next;
            prev_top_reg    <= prev_top_next;
            prev_bottom_reg <= prev_bottom_next;
            prev_empty_reg  <= prev_empty_next;
        end
    end

    always_ff @(posedge aclk) begin
        t1_reg    <= t1_next;
        b1_reg    <= b1_next;
        ot_reg    <= ot_next;
        ob_reg    <= ob_next;
        fr_reg    <= fr_next;
        t2_reg    <= t2_next;
        b2_reg    <= b2_next;
        x_reg     <= x_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
    end

    always_comb begin
        in_t2 = cts_pkg::idx_t'(IDX_ZEXT(s_data.top_row));
        in_b2 = cts_pkg::idx_t'(IDX_ZEXT(s_data.bottom_row));
        if (in_b2 > cts_pkg::IDX_LASTROW) begin
            in_b2 = cts_pkg::IDX_LASTROW;
        end
        in_empty = in_t2 > in_b2;
        if (s_data.first_col || prev_empty_reg) begin
            in_t1 = cts_pkg::IDX_ROWS;
            in_b1 = cts_pkg::IDX_NONE;
        end else begin
            in_t1 = prev_top_reg;
            in_b1 = prev_bottom_reg;
        end
        in_view = 32'(s_data.column) < cts_pkg::COLUMNS;
    end

    always_comb begin
        state_next       = state_reg;
        t1_next          = t1_reg;
        b1_next          = b1_reg;
        ot_next          = ot_reg;
        ob_next          = ob_reg;
        fr_next          = fr_reg;
        t2_next          = t2_reg;
        b2_next          = b2_reg;
        x_next           = x_reg;
        last_next        = last_reg;
        empty_next       = empty_reg;
        prev_top_next    = prev_top_reg;
        prev_bottom_next = prev_bottom_reg;
        prev_empty_next  = prev_empty_reg;
        s_ready          = 1'b0;
        req              = '0;

        unique case (state_reg)
            cts_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && in_view) begin
                    t1_next          = in_t1;
                    b1_next          = in_b1;
                    ot_next          = in_t2;
                    ob_next          = in_b2;
                    fr_next          = in_t2;
                    t2_next          = in_t2;
                    b2_next          = in_b2;
                    x_next           = s_data.column;
                    last_next        = s_data.last_col;
                    empty_next       = in_empty;
                    prev_top_next    = in_t2;
                    prev_bottom_next = in_b2;
                    prev_empty_next  = in_empty || s_data.last_col;
                    state_next = next_phase(in_t1, in_b1, in_t2, in_b2, in_t2, in_t2,
                                            in_b2, in_empty, s_data.last_col);
                end
            end
            cts_pkg::ST_CLOSE_TOP: begin
                if (issue_ok) begin
                    t1_next      = t1_reg + cts_pkg::idx_t'(1);
                    req.rd_en    = 1'b1;
                    req.row      = t1_reg[cts_pkg::ROW_FW-1:0];
                    req.col      = x_reg - cts_pkg::COL_FW'(1);
                    req.run_last = !more_spans(t1_next, b1_reg, fr_reg, t2_reg, b2_reg,
                                               empty_reg, last_reg);
                    state_next   = next_phase(t1_next, b1_reg, ot_reg, ob_reg, fr_reg,
                                              t2_reg, b2_reg, empty_reg, last_reg);
                end
            end
            cts_pkg::ST_CLOSE_BOT: begin
                if (issue_ok) begin
                    b1_next      = b1_reg - cts_pkg::idx_t'(1);
                    req.rd_en    = 1'b1;
                    req.row      = b1_reg[cts_pkg::ROW_FW-1:0];
                    req.col      = x_reg - cts_pkg::COL_FW'(1);
                    req.run_last = !more_spans(t1_reg, b1_next, fr_reg, t2_reg, b2_reg,
                                               empty_reg, last_reg);
                    state_next   = next_phase(t1_reg, b1_next, ot_reg, ob_reg, fr_reg,
                                              t2_reg, b2_reg, empty_reg, last_reg);
                end
            end
            cts_pkg::ST_OPEN_TOP: begin
                ot_next    = ot_reg + cts_pkg::idx_t'(1);
                req.wr_en  = 1'b1;
                req.row    = ot_reg[cts_pkg::ROW_FW-1:0];
                req.col    = x_reg;
                state_next = next_phase(t1_reg, b1_reg, ot_next, ob_reg, fr_reg,
                                        t2_reg, b2_reg, empty_reg, last_reg);
            end
            cts_pkg::ST_OPEN_BOT: begin
                ob_next    = ob_reg - cts_pkg::idx_t'(1);
                req.wr_en  = 1'b1;
                req.row    = ob_reg[cts_pkg::ROW_FW-1:0];
                req.col    = x_reg;
                state_next = next_phase(t1_reg, b1_reg, ot_reg, ob_next, fr_reg,
                                        t2_reg, b2_reg, empty_reg, last_reg);
            end
            cts_pkg::ST_FLUSH: begin
                if (issue_ok) begin
                    fr_next      = fr_reg + cts_pkg::idx_t'(1);
                    req.rd_en    = 1'b1;
                    req.row      = fr_reg[cts_pkg::ROW_FW-1:0];
                    req.col      = x_reg;
                    req.run_last = !more_spans(t1_reg, b1_reg, fr_next, t2_reg, b2_reg,
                                               empty_reg, last_reg);
                    state_next   = next_phase(t1_reg, b1_reg, ot_reg, ob_reg, fr_next,
                                              t2_reg, b2_reg, empty_reg, last_reg);
                end
            end
            default: begin
                state_next = cts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
